// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the pattern unpacker.
// No dependencies; include before any module that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is active
`define TPU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tracker_pattern_unpacker: check failed");
// Next-cycle implication, disabled while reset is active
`define TPU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tracker_pattern_unpacker: check failed");
`else
`define TPU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TPU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/tpu_pkg.sv =====
// Package for the tracker pattern unpacker: byte codes, parse phases,
// controller states and the command/status structs. No dependencies.
package tpu_pkg;

  localparam int unsigned MaxRowsDefault = 128;
  localparam logic [7:0]  RestCodeReset  = 8'hBD;

  // Byte codes
  localparam logic [7:0] ByteEnd     = 8'h00;
  localparam logic [1:0] InstrHi     = 2'b00;  // 0x01-0x3F
  localparam logic [3:0] CmdNoteHi   = 4'h4;   // 0x40-0x4F
  localparam logic [3:0] CmdRestHi   = 4'h5;   // 0x50-0x5F
  localparam logic [1:0] RestRunHi   = 2'b11;  // 0xC0-0xFF
  localparam logic [3:0] CmdTempo    = 4'hF;
  localparam logic [3:0] CmdNone     = 4'h0;

  typedef enum logic [2:0] {
    PH_CODE        = 3'd0,
    PH_AFTER_INSTR = 3'd1,
    PH_FX_ARG      = 3'd2,
    PH_NOTE        = 3'd3,
    PH_REST_ARG    = 3'd4,
    PH_DONE        = 3'd5
  } phase_e;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_RUN  = 1'b1
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // take the input byte, load the first result
    logic advance;  // load the next row of a rest run
  } tpu_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_result;  // the byte on the input gives a result
    logic more_rows;   // that result opens a run of further rows
    logic run_last;    // one row of the run remains
  } tpu_status_t;

  // Tempo command: arguments of 2 or more are raised by one
  function automatic logic [7:0] adjust_arg(input logic [3:0] cmd, input logic [7:0] a);
    logic [7:0] r;
    r = a;
    if (cmd == CmdTempo && a >= 8'd2) r = a + 8'd1;
    return r;
  endfunction

endpackage

// ===== src/tracker_pattern_unpacker.sv =====
// A result appears in the output register in the cycle after its byte is taken; a byte
// with no result gives none. One byte per cycle while the output is not stalled. A rest
// run holds the input; the run counter feeds the output register one row per free cycle.
// Reset (rst_ni, asynchronous, active low): parser back to code-byte phase, sticky
// values and row count cleared, rest code set to 0xBD, output empty.
`include "assert_macros.svh"
module tracker_pattern_unpacker
  import tpu_pkg::*;
#(
  parameter int unsigned MAX_ROWS = MaxRowsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_rest_code_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       start_of_pattern_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] note_o,
  output logic [5:0] instrument_o,
  output logic [3:0] command_o,
  output logic [7:0] argument_o,
  output logic       has_row_o,
  output logic       pattern_done_o,
  output logic [7:0] rows_total_o,
  output logic       last_of_run_o
);

  tpu_cmd_t    cmd;
  tpu_status_t status;

  // Configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  tpu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tpu_datapath #(
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_valid_i && cfg_ready_o),
    .cfg_rest_code_i    (cfg_rest_code_i),
    .data_byte_i        (data_byte_i),
    .start_of_pattern_i (start_of_pattern_i),
    .final_byte_i       (final_byte_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .note_o             (note_o),
    .instrument_o       (instrument_o),
    .command_o          (command_o),
    .argument_o         (argument_o),
    .has_row_o          (has_row_o),
    .pattern_done_o     (pattern_done_o),
    .rows_total_o       (rows_total_o),
    .last_of_run_o      (last_of_run_o)
  );

  // Run rows go out only while the input is held
  `TPU_ASSERT_IMP(a_advance_stalls, clk_i, rst_ni, cmd.advance, in_stall_o)
  // A byte that opens a run holds the input in the next cycle
  `TPU_ASSERT_NXT(a_run_holds_input, clk_i, rst_ni,
                  cmd.accept && status.has_result && status.more_rows, in_stall_o)
  // Pattern end is always the last transfer of its byte
  `TPU_ASSERT_IMP(a_done_is_last, clk_i, rst_ni, out_valid_o && pattern_done_o, last_of_run_o)
  // A bare end carries the end flags; a row count stays within the limit
  `TPU_ASSERT_IMP(a_bare_end, clk_i, rst_ni, out_valid_o && !has_row_o,
                  pattern_done_o && last_of_run_o)
  `TPU_ASSERT_IMP(a_row_count, clk_i, rst_ni, out_valid_o && has_row_o,
                  rows_total_o != 8'd0 && rows_total_o <= MAX_ROWS)

endmodule

// ===== src/tpu_ctrl.sv =====
// Controller of the pattern unpacker: input/output handshake and run sequencing.
// Depends on tpu_pkg.
module tpu_ctrl
  import tpu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  tpu_status_t status_i,
  output tpu_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: begin
        if (in_valid_i && slot_free && status_i.has_result && status_i.more_rows) begin
          state_d = CS_RUN;
        end
      end
      CS_RUN: begin
        if (slot_free && status_i.run_last) state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  // Handshake and datapath commands
  always_comb begin
    in_stall_o     = 1'b1;
    cmd_o.accept   = 1'b0;
    cmd_o.advance  = 1'b0;
    out_valid_d    = out_valid_q && out_stall_i;
    unique case (state_q)
      CS_IDLE: begin
        in_stall_o   = !slot_free;
        cmd_o.accept = in_valid_i && slot_free;
        if (cmd_o.accept) out_valid_d = status_i.has_result;
      end
      CS_RUN: begin
        cmd_o.advance = slot_free;
        if (slot_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/tpu_datapath.sv =====
// Datapath of the pattern unpacker: decoder state, byte decode, rest-run counter
// and output register. Depends on tpu_pkg.
module tpu_datapath
  import tpu_pkg::*;
#(
  parameter int unsigned MAX_ROWS = MaxRowsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_rest_code_i,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_pattern_i,
  input  logic        final_byte_i,
  input  tpu_cmd_t    cmd_i,
  output tpu_status_t status_o,
  output logic [7:0]  note_o,
  output logic [5:0]  instrument_o,
  output logic [3:0]  command_o,
  output logic [7:0]  argument_o,
  output logic        has_row_o,
  output logic        pattern_done_o,
  output logic [7:0]  rows_total_o,
  output logic        last_of_run_o
);

  localparam logic [7:0] MaxRowsB = 8'(MAX_ROWS);

  // Decoder state
  phase_e     phase_q;
  logic [5:0] si_q, ri_q;
  logic [3:0] sc_q;
  logic [7:0] sa_q, rc_q, rest_code_q;
  logic [6:0] rem_q;
  logic       done_pend_q;

  // Output register
  logic [7:0] note_q, arg_q, total_q;
  logic [5:0] ins_q;
  logic [3:0] cmd_q;
  logic       has_row_q, done_q, last_q;

  // Effective state after an optional pattern restart
  phase_e     ph;
  logic [5:0] si, ri;
  logic [3:0] sc;
  logic [7:0] sa, rc;

  // Decode results
  phase_e     nx_ph;
  logic [5:0] nx_si, nx_ri;
  logic [3:0] nx_sc;
  logic [7:0] nx_sa, nx_rc;
  logic       row_en, bare_en;
  logic [7:0] row_note;
  logic [5:0] row_ins;
  logic [6:0] row_n;

  // Note-byte helpers
  logic [7:0] b, room;
  logic [6:0] cnt;
  logic       nb_run, nb_limit, one_limit;
  logic [6:0] nb_n;
  logic [7:0] nb_note;
  logic [5:0] nb_ins, nb_ins_code;

  always_comb begin
    if (start_of_pattern_i) begin
      ph = PH_CODE;
      si = '0;
      ri = '0;
      sc = '0;
      sa = '0;
      rc = '0;
    end else begin
      ph = phase_q;
      si = si_q;
      ri = ri_q;
      sc = sc_q;
      sa = sa_q;
      rc = rc_q;
    end
  end

  // Note byte: a single row, or a rest run cut at the row limit
  always_comb begin
    b         = data_byte_i;
    room      = MaxRowsB - rc;
    cnt       = 7'(9'd256 - {1'b0, b});
    nb_run    = (b[7:6] == RestRunHi);
    one_limit = (room == 8'd1);
    nb_limit  = nb_run ? ({1'b0, cnt} >= room) : one_limit;
    if (nb_run) begin
      nb_n = ({1'b0, cnt} >= room) ? room[6:0] : cnt;
    end else begin
      nb_n = 7'd1;
    end
    nb_note     = nb_run ? rest_code_q : b;
    nb_ins      = (nb_run || b == rest_code_q) ? 6'd0 : ((ri != 6'd0) ? ri : si);
    nb_ins_code = (nb_run || b == rest_code_q) ? 6'd0 : si;
  end

  // Byte decode
  always_comb begin
    nx_ph    = ph;
    nx_si    = si;
    nx_ri    = ri;
    nx_sc    = sc;
    nx_sa    = sa;
    row_en   = 1'b0;
    row_note = nb_note;
    row_ins  = nb_ins;
    row_n    = 7'd1;
    case (ph)
      PH_CODE, PH_AFTER_INSTR: begin
        if (b == ByteEnd) begin
          nx_ph = PH_DONE;
        end else if (ph == PH_CODE && b[7:6] == InstrHi) begin
          nx_si = b[5:0];
          nx_ri = b[5:0];
          nx_ph = final_byte_i ? PH_DONE : PH_AFTER_INSTR;
        end else begin
          if (ph == PH_CODE) nx_ri = '0;
          if (b[7:4] == CmdNoteHi) begin
            nx_sc = b[3:0];
            nx_sa = '0;
            if (final_byte_i) nx_ph = PH_DONE;
            else nx_ph = (b[3:0] != CmdNone) ? PH_FX_ARG : PH_NOTE;
          end else if (b[7:4] == CmdRestHi) begin
            nx_sc = b[3:0];
            nx_sa = '0;
            if (b[3:0] != CmdNone && !final_byte_i) begin
              nx_ph = PH_REST_ARG;
            end else begin
              row_en   = 1'b1;
              row_note = rest_code_q;
              row_ins  = '0;
              nx_ri    = '0;
              nx_ph    = (final_byte_i || one_limit) ? PH_DONE : PH_CODE;
            end
          end else begin
            row_en  = 1'b1;
            row_n   = nb_n;
            row_ins = (ph == PH_CODE) ? nb_ins_code : nb_ins;
            nx_ri   = '0;
            nx_ph   = (final_byte_i || nb_limit) ? PH_DONE : PH_CODE;
          end
        end
      end
      PH_FX_ARG: begin
        nx_sa = adjust_arg(sc, b);
        nx_ph = final_byte_i ? PH_DONE : PH_NOTE;
      end
      PH_NOTE: begin
        row_en = 1'b1;
        row_n  = nb_n;
        nx_ri  = '0;
        nx_ph  = (final_byte_i || nb_limit) ? PH_DONE : PH_CODE;
      end
      PH_REST_ARG: begin
        nx_sa    = adjust_arg(sc, b);
        row_en   = 1'b1;
        row_note = rest_code_q;
        row_ins  = '0;
        nx_ri    = '0;
        nx_ph    = (final_byte_i || one_limit) ? PH_DONE : PH_CODE;
      end
      PH_DONE: ;
      default: nx_ph = PH_DONE;
    endcase
    bare_en = (ph != PH_DONE) && !row_en && (nx_ph == PH_DONE);
    nx_rc   = row_en ? (rc + {1'b0, row_n}) : rc;
  end

  assign status_o.has_result = row_en || bare_en;
  assign status_o.more_rows  = row_en && (row_n != 7'd1);
  assign status_o.run_last   = (rem_q == 7'd1);

  // Control state: decoder registers, run counter, rest code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CODE;
      si_q        <= '0;
      ri_q        <= '0;
      sc_q        <= '0;
      sa_q        <= '0;
      rc_q        <= '0;
      rem_q       <= '0;
      done_pend_q <= 1'b0;
      rest_code_q <= RestCodeReset;
    end else begin
      if (cfg_we_i) rest_code_q <= cfg_rest_code_i;
      if (cmd_i.accept) begin
        phase_q     <= nx_ph;
        si_q        <= nx_si;
        ri_q        <= nx_ri;
        sc_q        <= nx_sc;
        sa_q        <= nx_sa;
        rc_q        <= nx_rc;
        rem_q       <= row_n - 7'd1;
        done_pend_q <= (nx_ph == PH_DONE);
      end else if (cmd_i.advance) begin
        rem_q <= rem_q - 7'd1;
      end
    end
  end

  // Output register: load the first result, then step through the run
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && row_en) begin
      note_q    <= row_note;
      ins_q     <= row_ins;
      cmd_q     <= nx_sc;
      arg_q     <= nx_sa;
      has_row_q <= 1'b1;
      total_q   <= rc + 8'd1;
      last_q    <= (row_n == 7'd1);
      done_q    <= (row_n == 7'd1) && (nx_ph == PH_DONE);
    end else if (cmd_i.accept && bare_en) begin
      note_q    <= '0;
      ins_q     <= '0;
      cmd_q     <= '0;
      arg_q     <= '0;
      has_row_q <= 1'b0;
      total_q   <= rc;
      last_q    <= 1'b1;
      done_q    <= 1'b1;
    end else if (cmd_i.advance) begin
      total_q <= total_q + 8'd1;
      last_q  <= (rem_q == 7'd1);
      done_q  <= (rem_q == 7'd1) && done_pend_q;
    end
  end

  assign note_o         = note_q;
  assign instrument_o   = ins_q;
  assign command_o      = cmd_q;
  assign argument_o     = arg_q;
  assign has_row_o      = has_row_q;
  assign pattern_done_o = done_q;
  assign rows_total_o   = total_q;
  assign last_of_run_o  = last_q;

endmodule
